FILE: hdl/gdfs_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// graph depth-first search core. No dependencies.
`default_nettype none

package gdfs_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int MAX_DEGREE   = 8;

   localparam int OP_W     = 2;
   localparam int VERTEX_W = $clog2(MAX_VERTICES);
   localparam int SLOT_W   = $clog2(MAX_DEGREE);
   localparam int DEG_W    = $clog2(MAX_DEGREE + 1);
   localparam int DEPTH_W  = $clog2(MAX_VERTICES + 1);
   localparam int CFG_W    = 5;
   localparam int STATUS_W = 2;
   localparam int ADJ_AW   = VERTEX_W + SLOT_W;
   localparam int ADJ_DEPTH = MAX_VERTICES * MAX_DEGREE;

   localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(16);

   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_W-1:0] OP_TRAV  = 2'd2;
   localparam logic [OP_W-1:0] OP_PATH  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_PATH = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic                latch_req;
      logic                clear_deg;
      logic                load_da;
      logic                load_db;
      logic                edge_wr1;
      logic                edge_wr2;
      logic                start;
      logic                fetch;
      logic                pop;
      logic                push;
      logic                out_load;
      logic                out_status_only;
      logic [STATUS_W-1:0] out_status;
   } gdfs_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            a_ok;
      logic            b_ok;
      logic            edge_full;
      logic            start_is_target;
      logic            stack_empty;
      logic            has_next;
      logic            nb_new;
      logic            nb_is_target;
      logic            emit_last;
      logic            out_free;
   } gdfs_stat_type;

endpackage

`default_nettype wire

FILE: hdl/gdfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gdfs_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/gdfs_datapath.sv
// Datapath of the search core: request and config registers, degree counts,
// adjacency RAM, visit marks, walk stack, preorder buffer and result register.
// Depends on gdfs_pkg and gdfs_ram.
`default_nettype none

module gdfs_datapath import gdfs_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [OP_W-1:0]     req_opcode,
   input  wire logic [VERTEX_W-1:0] req_vertex_a,
   input  wire logic [VERTEX_W-1:0] req_vertex_b,
   input  wire logic                csr_valid,
   input  wire logic [CFG_W-1:0]    csr_vertex_count,
   input  wire logic                rsp_ready,
   output      logic                rsp_valid,
   output      logic [VERTEX_W-1:0] rsp_vertex_out,
   output      logic                rsp_last_of_run,
   output      logic [STATUS_W-1:0] rsp_status,
   input  wire gdfs_cmd_type        cmd,
   output      gdfs_stat_type       stat
);

   logic [OP_W-1:0]         op_ff;
   logic [VERTEX_W-1:0]     a_ff;
   logic [VERTEX_W-1:0]     b_ff;
   logic [CFG_W-1:0]        vcount_ff;
   logic [DEG_W-1:0]        deg_ff [MAX_VERTICES];
   logic [DEG_W-1:0]        da_ff;
   logic [DEG_W-1:0]        db_ff;
   logic [MAX_VERTICES-1:0] visited_ff;
   logic [VERTEX_W-1:0]     stk_v_ff [MAX_VERTICES];
   logic [DEG_W-1:0]        stk_i_ff [MAX_VERTICES];
   logic [VERTEX_W-1:0]     order_ff [MAX_VERTICES];
   logic [DEPTH_W-1:0]      depth_ff;
   logic [DEPTH_W-1:0]      n_ff;
   logic [VERTEX_W-1:0]     emit_ff;
   logic                    rsp_valid_ff;
   logic [VERTEX_W-1:0]     rsp_vertex_ff;
   logic                    rsp_last_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;

   logic [CFG_W-1:0]    lim;
   logic                self_loop;
   logic                is_path;
   logic [DEG_W:0]      da_plus2;
   logic [VERTEX_W-1:0] top;
   logic [VERTEX_W-1:0] stk_rv;
   logic [DEG_W-1:0]    top_idx;
   logic [DEG_W-1:0]    deg_rd;
   logic [DEPTH_W-1:0]  emit_count;
   logic [VERTEX_W-1:0] emit_vertex;
   logic                ram_we;
   logic [ADJ_AW-1:0]   ram_waddr;
   logic [VERTEX_W-1:0] ram_wdata;
   logic [ADJ_AW-1:0]   ram_raddr;
   logic [VERTEX_W-1:0] nb;

   // Request and configuration registers.
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff <= req_opcode;
         a_ff  <= req_vertex_a;
         b_ff  <= req_vertex_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_RESET;
      end else if (csr_valid) begin
         vcount_ff <= csr_vertex_count;
      end
   end

   assign lim       = (vcount_ff > CFG_W'(MAX_VERTICES)) ? CFG_W'(MAX_VERTICES) : vcount_ff;
   assign self_loop = (a_ff == b_ff);
   assign is_path   = (op_ff == OP_PATH);
   assign da_plus2  = (DEG_W+1)'(da_ff) + (DEG_W+1)'(2);

   // Stack top entry and the degree of its vertex.
   assign top     = VERTEX_W'(depth_ff - DEPTH_W'(1));
   assign stk_rv  = stk_v_ff[top];
   assign top_idx = stk_i_ff[top];
   assign deg_rd  = deg_ff[stk_rv];

   always_ff @(posedge clock) begin
      if (cmd.load_da) begin
         da_ff <= deg_ff[a_ff];
      end
      if (cmd.load_db) begin
         db_ff <= deg_ff[b_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_deg) begin
         for (int k = 0; k < MAX_VERTICES; k++) begin
            deg_ff[k] <= '0;
         end
      end else begin
         if (cmd.edge_wr1) begin
            deg_ff[a_ff] <= self_loop ? DEG_W'(da_plus2) : DEG_W'(da_ff + DEG_W'(1));
         end
         if (cmd.edge_wr2 && !self_loop) begin
            deg_ff[b_ff] <= DEG_W'(db_ff + DEG_W'(1));
         end
      end
   end

   // Adjacency store: slot address is vertex then list position.
   always_comb begin
      ram_we    = cmd.edge_wr1 || cmd.edge_wr2;
      ram_waddr = {a_ff, da_ff[SLOT_W-1:0]};
      ram_wdata = b_ff;
      if (cmd.edge_wr2) begin
         ram_wdata = a_ff;
         if (self_loop) begin
            ram_waddr = {a_ff, SLOT_W'(da_ff[SLOT_W-1:0] + SLOT_W'(1))};
         end else begin
            ram_waddr = {b_ff, db_ff[SLOT_W-1:0]};
         end
      end
   end

   assign ram_raddr = {stk_rv, top_idx[SLOT_W-1:0]};

   gdfs_ram #(
      .WIDTH (VERTEX_W),
      .DEPTH (ADJ_DEPTH)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.fetch),
      .rd_addr (ram_raddr),
      .rd_data (nb)
   );

   // Walk control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
         depth_ff   <= '0;
         n_ff       <= '0;
         emit_ff    <= '0;
      end else if (cmd.start) begin
         visited_ff <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_ff;
         depth_ff   <= DEPTH_W'(1);
         n_ff       <= DEPTH_W'(1);
         emit_ff    <= '0;
      end else begin
         if (cmd.pop) begin
            depth_ff <= depth_ff - DEPTH_W'(1);
         end
         if (cmd.push) begin
            visited_ff[nb] <= 1'b1;
            depth_ff       <= depth_ff + DEPTH_W'(1);
            if (!is_path) begin
               n_ff <= n_ff + DEPTH_W'(1);
            end
         end
         if (cmd.out_load && !cmd.out_status_only) begin
            emit_ff <= emit_ff + VERTEX_W'(1);
         end
      end
   end

   // Stack entries and the preorder buffer.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         stk_v_ff[0] <= a_ff;
         stk_i_ff[0] <= '0;
         order_ff[0] <= a_ff;
      end else begin
         if (cmd.fetch) begin
            stk_i_ff[top] <= top_idx + DEG_W'(1);
         end
         if (cmd.push) begin
            stk_v_ff[depth_ff[VERTEX_W-1:0]] <= nb;
            stk_i_ff[depth_ff[VERTEX_W-1:0]] <= '0;
            if (!is_path) begin
               order_ff[n_ff[VERTEX_W-1:0]] <= nb;
            end
         end
      end
   end

   // A path is sent from the bottom of the stack up.
   assign emit_count  = is_path ? depth_ff : n_ff;
   assign emit_vertex = is_path ? stk_v_ff[emit_ff] : order_ff[emit_ff];

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_vertex_ff <= cmd.out_status_only ? '0 : emit_vertex;
         rsp_last_ff   <= cmd.out_status_only ? 1'b1 : stat.emit_last;
         rsp_status_ff <= cmd.out_status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_vertex_out  = rsp_vertex_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_status      = rsp_status_ff;

   always_comb begin
      stat.opcode          = op_ff;
      stat.a_ok            = CFG_W'(a_ff) < lim;
      stat.b_ok            = CFG_W'(b_ff) < lim;
      stat.edge_full       = self_loop ? (da_plus2 > (DEG_W+1)'(MAX_DEGREE))
                                       : (da_ff >= DEG_W'(MAX_DEGREE) ||
                                          db_ff >= DEG_W'(MAX_DEGREE));
      stat.start_is_target = self_loop;
      stat.stack_empty     = (depth_ff == '0);
      stat.has_next        = (top_idx < deg_rd);
      stat.nb_new          = !visited_ff[nb];
      stat.nb_is_target    = (nb == b_ff);
      stat.emit_last       = ((DEPTH_W'(emit_ff) + DEPTH_W'(1)) == emit_count);
      stat.out_free        = !rsp_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

FILE: hdl/gdfs_ctrl.sv
// Controller state machine of the search core: sequences edge updates, the
// depth-first walk and result transfers. Depends on gdfs_pkg.
`default_nettype none

module gdfs_ctrl import gdfs_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire gdfs_stat_type stat,
   output      gdfs_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DECODE    = 4'd1;
   localparam logic [3:0] S_RESULT    = 4'd2;
   localparam logic [3:0] S_EDGE_RD_A = 4'd3;
   localparam logic [3:0] S_EDGE_RD_B = 4'd4;
   localparam logic [3:0] S_EDGE_CHK  = 4'd5;
   localparam logic [3:0] S_EDGE_WR1  = 4'd6;
   localparam logic [3:0] S_EDGE_WR2  = 4'd7;
   localparam logic [3:0] S_START     = 4'd8;
   localparam logic [3:0] S_FETCH     = 4'd9;
   localparam logic [3:0] S_CHECK     = 4'd10;
   localparam logic [3:0] S_EMIT      = 4'd11;

   logic [3:0]          state_ff;
   logic [3:0]          state_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic                is_path;

   assign is_path   = (stat.opcode == OP_PATH);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.opcode)
               OP_CLEAR: begin
                  cmd.clear_deg = 1'b1;
                  status_in     = ST_OK;
                  state_in      = S_RESULT;
               end
               OP_ADD: begin
                  if (!stat.a_ok || !stat.b_ok) begin
                     status_in = ST_RANGE;
                     state_in  = S_RESULT;
                  end else begin
                     state_in = S_EDGE_RD_A;
                  end
               end
               OP_TRAV: begin
                  if (!stat.a_ok) begin
                     status_in = ST_RANGE;
                     state_in  = S_RESULT;
                  end else begin
                     state_in = S_START;
                  end
               end
               default: begin
                  if (!stat.a_ok || !stat.b_ok) begin
                     status_in = ST_RANGE;
                     state_in  = S_RESULT;
                  end else begin
                     state_in = S_START;
                  end
               end
            endcase
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.out_load        = 1'b1;
               cmd.out_status_only = 1'b1;
               cmd.out_status      = status_ff;
               state_in            = S_IDLE;
            end
         end
         S_EDGE_RD_A: begin
            cmd.load_da = 1'b1;
            state_in    = S_EDGE_RD_B;
         end
         S_EDGE_RD_B: begin
            cmd.load_db = 1'b1;
            state_in    = S_EDGE_CHK;
         end
         S_EDGE_CHK: begin
            if (stat.edge_full) begin
               status_in = ST_FULL;
               state_in  = S_RESULT;
            end else begin
               state_in = S_EDGE_WR1;
            end
         end
         S_EDGE_WR1: begin
            cmd.edge_wr1 = 1'b1;
            state_in     = S_EDGE_WR2;
         end
         S_EDGE_WR2: begin
            cmd.edge_wr2 = 1'b1;
            status_in    = ST_OK;
            state_in     = S_RESULT;
         end
         S_START: begin
            cmd.start = 1'b1;
            if (is_path && stat.start_is_target) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (stat.stack_empty) begin
               if (is_path) begin
                  status_in = ST_NO_PATH;
                  state_in  = S_RESULT;
               end else begin
                  state_in = S_EMIT;
               end
            end else if (stat.has_next) begin
               cmd.fetch = 1'b1;
               state_in  = S_CHECK;
            end else begin
               cmd.pop = 1'b1;
            end
         end
         S_CHECK: begin
            // The neighbor read in the previous cycle is on the RAM output now.
            state_in = S_FETCH;
            if (stat.nb_new) begin
               cmd.push = 1'b1;
               if (is_path && stat.nb_is_target) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = ST_OK;
               if (stat.emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/graph_depth_first_search_core.sv
// Top level of the graph depth-first search core: joins the controller and
// the datapath. Depends on gdfs_pkg, gdfs_ctrl and gdfs_datapath.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   req_opcode, req_vertex_a, req_vertex_b
//   rsp      out        rsp_valid/rsp_ready   rsp_vertex_out, rsp_last_of_run, rsp_status
//   csr      in         csr_valid/csr_ready   csr_vertex_count
//
// One request is worked at a time. Clear and add edge each end by loading
// a single result. A walk examines each adjacency entry with a RAM read
// and then a visit check, and pops the stack when the top vertex has no
// entry left; the single read port of the adjacency RAM sets its pace.
// Results then go out one per cycle while rsp_ready stays high.
// Reset is synchronous; it clears degrees, marks, the stack and the count
// register (to 16). The adjacency RAM is not cleared. A stalled rsp_ready
// holds the controller in its result states while a result waits in the
// output register; the walk itself never waits.
`default_nettype none

module graph_depth_first_search_core import gdfs_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic [OP_W-1:0]     req_opcode,
   input  wire logic [VERTEX_W-1:0] req_vertex_a,
   input  wire logic [VERTEX_W-1:0] req_vertex_b,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic [VERTEX_W-1:0] rsp_vertex_out,
   output      logic                rsp_last_of_run,
   output      logic [STATUS_W-1:0] rsp_status,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [CFG_W-1:0]    csr_vertex_count
);

   gdfs_cmd_type  cmd;
   gdfs_stat_type stat;

   // The count register takes every write transfer at once.
   assign csr_ready = 1'b1;

   gdfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gdfs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_opcode),
      .req_vertex_a     (req_vertex_a),
      .req_vertex_b     (req_vertex_b),
      .csr_valid        (csr_valid),
      .csr_vertex_count (csr_vertex_count),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_vertex_out   (rsp_vertex_out),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_status       (rsp_status),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

`default_nettype wire

FILE: hdl/gdfs_checker.sv
// Port-level checks for the search core, bound to the top level.
// Depends on gdfs_pkg and graph_depth_first_search_core.
`default_nettype none

module gdfs_checker import gdfs_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic [OP_W-1:0]     req_opcode,
   input wire logic [VERTEX_W-1:0] req_vertex_a,
   input wire logic [VERTEX_W-1:0] req_vertex_b,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [VERTEX_W-1:0] rsp_vertex_out,
   input wire logic                rsp_last_of_run,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic                csr_valid,
   input wire logic                csr_ready,
   input wire logic [CFG_W-1:0]    csr_vertex_count
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vertex_out) &&
      $stable(rsp_last_of_run) && $stable(rsp_status))
      else $error("result changed while stalled");

   // Any result other than success is a lone status result.
   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_vertex_out == '0 && rsp_last_of_run)
      else $error("status result carries a vertex or is not last");

   // No new request is taken while a run still has results to send.
   a_no_req_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !req_ready)
      else $error("request taken in the middle of a run");

   // A request transfer is followed by a busy cycle.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request ready right after a transfer");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind graph_depth_first_search_core gdfs_checker u_gdfs_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_graph_depth_first_search_core.sv
// Self-checking testbench for graph_depth_first_search_core: directed and random
// edge, traversal and path requests checked against a built-in graph predictor.
// Depends on gdfs_pkg and the graph_depth_first_search_core RTL.
`timescale 1ns / 100ps

module tb_graph_depth_first_search_core;
   import gdfs_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int NUM_PHASES  = 9;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic                last;
      logic [STATUS_W-1:0] status;
   } dfs_visit_type;

   // Mirrors the graph held by the core and predicts the visit sequence
   // that each accepted request produces.
   class dfs_scoreboard_type;
      logic [VERTEX_W-1:0] adjacency [MAX_VERTICES][MAX_DEGREE];
      int unsigned         degree [MAX_VERTICES];
      logic [CFG_W-1:0]    vertex_count;
      dfs_visit_type       expected_visits [$];
      int                  errors;

      function new();
         vertex_count = VCOUNT_RESET;
         for (int i = 0; i < MAX_VERTICES; i++) begin
            degree[i] = 0;
         end
         errors = 0;
      endfunction

      function void set_vertex_count(logic [CFG_W-1:0] value);
         vertex_count = value;
      endfunction

      function int pending();
         return expected_visits.size();
      endfunction

      function void expect_status(logic [STATUS_W-1:0] st);
         dfs_visit_type r;
         r.vertex = '0;
         r.last   = 1'b1;
         r.status = st;
         expected_visits = {expected_visits, r};
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [VERTEX_W-1:0] a,
                                 logic [VERTEX_W-1:0] b);
         int unsigned         lim;
         bit                  visited [MAX_VERTICES];
         logic [VERTEX_W-1:0] stack_vertex [MAX_VERTICES];
         int unsigned         stack_slot [MAX_VERTICES];
         int unsigned         depth;
         bit                  found;
         logic [VERTEX_W-1:0] v;
         logic [VERTEX_W-1:0] nb;
         logic [VERTEX_W-1:0] order [$];
         dfs_visit_type       r;

         lim = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : vertex_count;
         case (op)
            OP_CLEAR: begin
               for (int i = 0; i < MAX_VERTICES; i++) begin
                  degree[i] = 0;
               end
               expect_status(ST_OK);
            end
            OP_ADD: begin
               if (a >= lim || b >= lim) begin
                  expect_status(ST_RANGE);
               end else if (a == b) begin
                  // A self loop takes two slots of the same list.
                  if (degree[a] + 2 > MAX_DEGREE) begin
                     expect_status(ST_FULL);
                  end else begin
                     adjacency[a][degree[a]] = a;
                     adjacency[a][degree[a] + 1] = a;
                     degree[a] += 2;
                     expect_status(ST_OK);
                  end
               end else if (degree[a] >= MAX_DEGREE || degree[b] >= MAX_DEGREE) begin
                  expect_status(ST_FULL);
               end else begin
                  adjacency[a][degree[a]] = b;
                  adjacency[b][degree[b]] = a;
                  degree[a]++;
                  degree[b]++;
                  expect_status(ST_OK);
               end
            end
            default: begin
               if (a >= lim || (op == OP_PATH && b >= lim)) begin
                  expect_status(ST_RANGE);
                  return;
               end
               for (int i = 0; i < MAX_VERTICES; i++) begin
                  visited[i] = 1'b0;
               end
               visited[a]      = 1'b1;
               stack_vertex[0] = a;
               stack_slot[0]   = 0;
               depth           = 1;
               found           = (op == OP_PATH && a == b);
               if (op == OP_TRAV) begin
                  order = {order, a};
               end
               // Recursive preorder kept as an explicit stack of
               // (vertex, next list slot) pairs.
               while (depth > 0 && !found) begin
                  v = stack_vertex[depth - 1];
                  if (stack_slot[depth - 1] < degree[v]) begin
                     nb = adjacency[v][stack_slot[depth - 1]];
                     stack_slot[depth - 1]++;
                     if (!visited[nb]) begin
                        visited[nb]         = 1'b1;
                        stack_vertex[depth] = nb;
                        stack_slot[depth]   = 0;
                        depth++;
                        if (op == OP_PATH) begin
                           found = (nb == b);
                        end else begin
                           order = {order, nb};
                        end
                     end
                  end else begin
                     depth--;
                  end
               end
               if (op == OP_PATH) begin
                  if (!found) begin
                     expect_status(ST_NO_PATH);
                     return;
                  end
                  // The stack holds the path from start to target.
                  for (int i = 0; i < depth; i++) begin
                     order = {order, stack_vertex[i]};
                  end
               end
               for (int i = 0; i < order.size(); i++) begin
                  r.vertex = order[i];
                  r.last   = (i == order.size() - 1);
                  r.status = ST_OK;
                  expected_visits = {expected_visits, r};
               end
            end
         endcase
      endfunction

      function void check_result(dfs_visit_type got);
         dfs_visit_type want;
         if (expected_visits.size() == 0) begin
            $display("%0t: unexpected result vertex %0d last %0d status %0d", $time,
                     got.vertex, got.last, got.status);
            errors++;
            return;
         end
         want = expected_visits.pop_front();
         if (got !== want) begin
            $display("%0t: expected vertex %0d last %0d status %0d, %s %0d last %0d status %0d",
                     $time, want.vertex, want.last, want.status, "got vertex",
                     got.vertex, got.last, got.status);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [OP_W-1:0]     req_opcode;
   logic [VERTEX_W-1:0] req_vertex_a;
   logic [VERTEX_W-1:0] req_vertex_b;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [VERTEX_W-1:0] rsp_vertex_out;
   logic                rsp_last_of_run;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_valid;
   logic                csr_ready;
   logic [CFG_W-1:0]    csr_vertex_count;

   dfs_scoreboard_type sb;
   int            send_idle_pct  = 0;
   int            recv_stall_pct = 0;
   bit            rsp_hold_request = 1'b0;
   int            quiet_cycles = 0;

   graph_depth_first_search_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_vertex_a     (req_vertex_a),
      .req_vertex_b     (req_vertex_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vertex_out   (rsp_vertex_out),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_vertex_count (csr_vertex_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Observe every transfer at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_result({rsp_vertex_out, rsp_last_of_run, rsp_status});
         end
         if (req_valid && req_ready) begin
            sb.note_request(req_opcode, req_vertex_a, req_vertex_b);
         end
         if (csr_valid && csr_ready) begin
            sb.set_vertex_count(csr_vertex_count);
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            hold_left        = HOLD_CYCLES;
            rsp_hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(negedge clock);
      end
      $display("tb_graph_depth_first_search_core: done, errors");
      $finish;
   end

   // Called at a falling edge; returns at a falling edge with valid still high
   // so that back-to-back transfers keep valid asserted.
   task automatic send_request(logic [OP_W-1:0] op, logic [VERTEX_W-1:0] a,
                               logic [VERTEX_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_vertex_a <= a;
      req_vertex_b <= b;
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() > 0) begin
         @(negedge clock);
      end
      // Let the core settle back to idle after the last transfer.
      repeat (8) @(negedge clock);
   endtask

   task automatic write_vertex_count(logic [CFG_W-1:0] value);
      csr_valid        <= 1'b1;
      csr_vertex_count <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [VERTEX_W-1:0] pick_vertex(int unsigned lim);
      if (lim == 0 || $urandom_range(99) < 8) begin
         return VERTEX_W'($urandom_range(MAX_VERTICES - 1));
      end
      return VERTEX_W'($urandom_range(lim - 1));
   endfunction

   task automatic run_random(int count, int unsigned lim);
      int              roll;
      logic [OP_W-1:0] op;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (roll < 4) begin
            op = OP_CLEAR;
         end else if (roll < 52) begin
            op = OP_ADD;
         end else if (roll < 76) begin
            op = OP_TRAV;
         end else begin
            op = OP_PATH;
         end
         send_request(op, pick_vertex(lim), pick_vertex(lim));
         // Now and then the sender waits until every visit has come back.
         if ($urandom_range(29) == 0) begin
            wait_drained();
         end
      end
   endtask

   initial begin
      int unsigned phase_vcount [NUM_PHASES] = '{16, 5, 0, 31, 1, 2, 12, 16, 0};
      int          phase_items  [NUM_PHASES] = '{50, 45, 10, 50, 15, 20, 50, 60, 50};
      int          send_pct     [4] = '{0, 53, 0, 20};
      int          recv_pct     [4] = '{0, 0, 53, 20};
      int unsigned vcount;

      sb               = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OP_CLEAR;
      req_vertex_a     = '0;
      req_vertex_b     = '0;
      csr_valid        = 1'b0;
      csr_vertex_count = VCOUNT_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Small graph: a ring of four vertices 0-1-3-2 with a tail 3-15-14 and a self loop.
      send_request(OP_CLEAR, 4'd0, 4'd0);
      send_request(OP_ADD, 4'd0, 4'd1);
      send_request(OP_ADD, 4'd0, 4'd2);
      send_request(OP_ADD, 4'd1, 4'd3);
      send_request(OP_ADD, 4'd2, 4'd3);
      send_request(OP_ADD, 4'd3, 4'd15);
      send_request(OP_ADD, 4'd15, 4'd14);
      send_request(OP_ADD, 4'd4, 4'd4);
      send_request(OP_TRAV, 4'd0, 4'd0);
      send_request(OP_PATH, 4'd0, 4'd2);
      send_request(OP_PATH, 4'd0, 4'd4);
      send_request(OP_PATH, 4'd3, 4'd3);
      send_request(OP_TRAV, 4'd4, 4'd9);
      send_request(OP_TRAV, 4'd15, 4'd0);
      // Fill vertex 6 so that a self loop finds one slot free, and a later edge finds none.
      send_request(OP_ADD, 4'd6, 4'd6);
      send_request(OP_ADD, 4'd6, 4'd6);
      send_request(OP_ADD, 4'd6, 4'd6);
      send_request(OP_ADD, 4'd6, 4'd7);
      send_request(OP_ADD, 4'd6, 4'd6);
      send_request(OP_ADD, 4'd6, 4'd8);
      send_request(OP_ADD, 4'd6, 4'd9);
      wait_drained();

      // Shrink the vertex range; stored edges to high ids are still walked.
      write_vertex_count(5'd5);
      send_request(OP_ADD, 4'd5, 4'd0);
      send_request(OP_ADD, 4'd0, 4'd9);
      send_request(OP_TRAV, 4'd7, 4'd0);
      send_request(OP_PATH, 4'd0, 4'd12);
      send_request(OP_TRAV, 4'd0, 4'd0);
      send_request(OP_PATH, 4'd0, 4'd3);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         vcount = (p == NUM_PHASES - 1) ? $urandom_range(31) : phase_vcount[p];
         write_vertex_count(CFG_W'(vcount));
         send_idle_pct  = send_pct[p % 4];
         recv_stall_pct = recv_pct[p % 4];
         if (p == 3) begin
            rsp_hold_request = 1'b1;
         end
         run_random(phase_items[p], (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount);
      end

      wait_drained();
      repeat (40) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_graph_depth_first_search_core: done, clean");
      end else begin
         $display("tb_graph_depth_first_search_core: done, errors");
      end
      $finish;
   end

endmodule
